// ----- rtl/core/estc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// estc_pkg: shared types and constants for the epoch seconds to calendar block
// Commands, controller states, status bundle, register indexes, calendar helpers.
// ----------------------------------------------------------------------------
package estc_pkg;

  // configuration register indexes
  localparam logic [3:0] REG_ZONE_OFFSET  = 4'd0;
  localparam logic [3:0] REG_ALARM_HOUR   = 4'd1;
  localparam logic [3:0] REG_ALARM_MINUTE = 4'd2;
  localparam logic [3:0] REG_ALARM_SECOND = 4'd3;

  localparam logic [16:0] ZONE_OFFSET_RST = 17'd28800;

  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;   // 1970-01-01 was a Thursday
  localparam logic [3:0]  LAST_MONTH    = 4'd12;
  // the only century year in 1970..2106 that is not a leap year
  localparam logic [11:0] CENTURY_NONLEAP = 12'd2100;

  localparam logic [16:0] DAY_SECONDS    = 17'd86400;
  localparam logic [11:0] HOUR_SECONDS   = 12'd3600;
  localparam logic [5:0]  MINUTE_SECONDS = 6'd60;
  localparam logic [2:0]  WEEK_DAYS      = 3'd7;

  // reciprocal divide, q = (n * RECIP) >> shift, exact over the dividend range used
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675, on seconds >> 7
  localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225, on seconds >> 4
  localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15, on seconds >> 2
  localparam logic [16:0] WEEK_RECIP = 17'd74899;     // 2^19 / 7

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DAY_QUO,
    CMD_DAY_REM,
    CMD_HOUR_QUO,
    CMD_HOUR_REM,
    CMD_MIN_QUO,
    CMD_MIN_REM,
    CMD_YEAR,
    CMD_MONTH,
    CMD_OUT
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY_QUO,
    S_DAY_REM,
    S_HOUR_QUO,
    S_HOUR_REM,
    S_MIN_QUO,
    S_MIN_REM,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
    logic out_free;
  } status_t;

  function automatic logic is_leap(input logic [11:0] y);
    is_leap = (y[1:0] == 2'b00) && (y != CENTURY_NONLEAP);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    month_len = len;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/estc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// estc channel interfaces
// Valid/ready channels for input counter beats, calendar results and config writes.
// ----------------------------------------------------------------------------
interface estc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] counter_seconds;
  modport source (output valid, output counter_seconds, input ready);
  modport sink (input valid, input counter_seconds, output ready);
endinterface

interface estc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;
  logic        alarm_match;
  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output weekday,
                  output alarm_match, input ready);
  modport sink (input valid, input year, input month, input day_of_month,
                input hour, input minute, input second, input weekday,
                input alarm_match, output ready);
endinterface

interface estc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [16:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/estc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// estc_ctrl: conversion sequencer
// Walks divide phases, year and month loops, at most one command a cycle.
// ----------------------------------------------------------------------------
module estc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire estc_pkg::status_t status,
  output estc_pkg::cmd_t         cmd
);
  import estc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DAY_QUO;
      S_DAY_QUO:  state_next = S_DAY_REM;
      S_DAY_REM:  state_next = S_HOUR_QUO;
      S_HOUR_QUO: state_next = S_HOUR_REM;
      S_HOUR_REM: state_next = S_MIN_QUO;
      S_MIN_QUO:  state_next = S_MIN_REM;
      S_MIN_REM:  state_next = S_YEAR;
      S_YEAR:     if (!status.year_more) state_next = S_MONTH;
      S_MONTH:    if (!status.month_more) state_next = S_DONE;
      S_DONE:     if (status.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      S_DAY_QUO:  cmd = CMD_DAY_QUO;
      S_DAY_REM:  cmd = CMD_DAY_REM;
      S_HOUR_QUO: cmd = CMD_HOUR_QUO;
      S_HOUR_REM: cmd = CMD_HOUR_REM;
      S_MIN_QUO:  cmd = CMD_MIN_QUO;
      S_MIN_REM:  cmd = CMD_MIN_REM;
      S_YEAR:     if (status.year_more) cmd = CMD_YEAR;
      S_MONTH:    if (status.month_more) cmd = CMD_MONTH;
      S_DONE:     if (status.out_free) cmd = CMD_OUT;
      default:    cmd = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/estc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// estc_dp: conversion datapath
// Config registers, reciprocal dividers, year/month subtract loop, result register.
// ----------------------------------------------------------------------------
module estc_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [31:0]       counter_seconds,
  input  wire estc_pkg::cmd_t    cmd,
  output estc_pkg::status_t      status,
  estc_cfg_if.sink               cfg,
  estc_out_if.source             out_ch
);
  import estc_pkg::*;

  // configuration
  logic [16:0] zone_offset;
  logic [4:0]  alarm_hour;
  logic [5:0]  alarm_minute;
  logic [5:0]  alarm_second;

  // working registers
  logic [31:0] rem;
  logic [15:0] days;
  logic [12:0] wk_quo;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;
  logic [11:0] year;
  logic [3:0]  month;

  // result register
  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;
  logic        out_match;

  logic [31:0] local_time;
  logic [50:0] day_prod;
  logic [31:0] day_secs;
  logic [15:0] wk_num;
  logic [31:0] wk_prod;
  logic [15:0] wk_rem;
  logic [25:0] hour_prod;
  logic [31:0] hour_secs;
  logic [19:0] min_prod;
  logic [11:0] sec_full;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  assign local_time = counter_seconds + {{15{zone_offset[16]}}, zone_offset};

  assign day_prod  = 51'(rem[31:7]) * 51'(DAY_RECIP);
  assign day_secs  = 32'(days) * 32'(DAY_SECONDS);
  assign wk_num    = days + EPOCH_WEEKDAY;
  assign wk_prod   = 32'(wk_num) * 32'(WEEK_RECIP);
  assign wk_rem    = wk_num - 16'(wk_quo) * 16'(WEEK_DAYS);
  assign hour_prod = 26'(rem[16:4]) * 26'(HOUR_RECIP);
  assign hour_secs = 32'(hour) * 32'(HOUR_SECONDS);
  assign min_prod  = 20'(rem[11:2]) * 20'(MIN_RECIP);
  assign sec_full  = rem[11:0] - 12'(minute) * 12'(MINUTE_SECONDS);

  assign leap = is_leap(year);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month, leap);

  assign status.year_more  = days >= {7'd0, ylen};
  assign status.month_more = (month < LAST_MONTH) && (days >= {11'd0, mlen});
  assign status.out_free   = !out_valid || out_ch.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset  <= ZONE_OFFSET_RST;
      alarm_hour   <= '0;
      alarm_minute <= '0;
      alarm_second <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ZONE_OFFSET:  zone_offset  <= cfg.data;
        REG_ALARM_HOUR:   alarm_hour   <= cfg.data[4:0];
        REG_ALARM_MINUTE: alarm_minute <= cfg.data[5:0];
        REG_ALARM_SECOND: alarm_second <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        rem <= local_time;
      end
      CMD_DAY_QUO: begin
        days <= day_prod[50:35];
      end
      CMD_DAY_REM: begin
        // remainder now holds the second of day
        rem    <= rem - day_secs;
        wk_quo <= wk_prod[31:19];
      end
      CMD_HOUR_QUO: begin
        hour    <= hour_prod[25:21];
        weekday <= wk_rem[2:0];
      end
      CMD_HOUR_REM: begin
        rem <= rem - hour_secs;
      end
      CMD_MIN_QUO: begin
        minute <= min_prod[19:14];
      end
      CMD_MIN_REM: begin
        second <= sec_full[5:0];
        year   <= EPOCH_YEAR;
        month  <= 4'd1;
      end
      CMD_YEAR: begin
        days <= days - {7'd0, ylen};
        year <= year + 12'd1;
      end
      CMD_MONTH: begin
        days  <= days - {11'd0, mlen};
        month <= month + 4'd1;
      end
      CMD_OUT: begin
        out_year    <= year;
        out_month   <= month;
        out_day     <= days[4:0] + 5'd1;
        out_hour    <= hour;
        out_minute  <= minute;
        out_second  <= second;
        out_weekday <= weekday;
        out_match   <= (hour == alarm_hour) && (minute == alarm_minute)
                       && (second == alarm_second);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.year         = out_year;
  assign out_ch.month        = out_month;
  assign out_ch.day_of_month = out_day;
  assign out_ch.hour         = out_hour;
  assign out_ch.minute       = out_minute;
  assign out_ch.second       = out_second;
  assign out_ch.weekday      = out_weekday;
  assign out_ch.alarm_match  = out_match;

endmodule
`default_nettype wire

// ----- rtl/core/epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// 32-bit epoch seconds plus zone offset to local Gregorian date, time, weekday, alarm.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  in_ch    in   counter_seconds[31:0]
//  out_ch   out  year, month, day_of_month, hour, minute, second, weekday, alarm_match
//  cfg      in   index[3:0], data[16:0]  (0 offset, 1 alarm hr, 2 alarm min, 3 alarm sec)
//
// A beat is loaded, then passes the reciprocal multiply and back-subtract phases for
// day, hour, minute and weekday, then one subtract per year past 1970 and per month
// passed before the result is loaded. A new beat is taken the cycle after the
// result is loaded.
// Sync reset clears the sequencer, the result valid and the config registers
// (offset 28800). A stalled result holds the block in its final state; cfg.ready is 1.
module epoch_seconds_to_calendar (
  input  wire logic  clk,
  input  wire logic  rst,
  estc_in_if.sink    in_ch,
  estc_out_if.source out_ch,
  estc_cfg_if.sink   cfg
);
  import estc_pkg::*;

  cmd_t    cmd;
  status_t status;

  estc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  estc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .counter_seconds (in_ch.counter_seconds),
    .cmd             (cmd),
    .status          (status),
    .cfg             (cfg),
    .out_ch          (out_ch)
  );

endmodule
`default_nettype wire
